// ===== rtl/ajst_pkg.sv =====
package ajst_pkg;

    localparam logic [39:0] PICO_SCALE       = 40'd1000000000000;
    localparam logic [47:0] RST_INITIAL_SIZE = 48'd268435456;
    localparam logic [47:0] RST_MAX_SIZE     = 48'd1099511627776;
    localparam logic [39:0] RST_MIN_JOB_TIME = 40'd0;
    localparam logic [15:0] RST_RATIO_Q8     = 16'd5120;
    localparam logic [11:0] RST_BOOST_Q8     = 12'd512;

    localparam logic [2:0] CFG_INITIAL_SIZE = 3'd0;
    localparam logic [2:0] CFG_MAX_SIZE     = 3'd1;
    localparam logic [2:0] CFG_MIN_JOB_TIME = 3'd2;
    localparam logic [2:0] CFG_RATIO_Q8     = 3'd3;
    localparam logic [2:0] CFG_BOOST_Q8     = 3'd4;

    typedef struct packed {
        logic [39:0] job_bytes;
        logic [39:0] prep_time_us;
        logic [39:0] exec_time_us;
        logic        abandoned;
    } t_in_item;

    typedef struct packed {
        logic [47:0] tuned_size;
        logic        sample_taken;
    } t_out_item;

    // Classified report as it travels from the front to the back.
    typedef struct packed {
        logic [39:0] job_bytes;
        logic [39:0] prep_time_us;
        logic [39:0] exec_time_us;
        logic        abandoned;
        logic        taken;
    } t_job;

    typedef struct packed {
        logic [47:0] max_size;
        logic [39:0] min_job_time_us;
        logic [15:0] ratio_q8;
        logic [11:0] boost_q8;
    } t_cfg;

    typedef enum logic [3:0] {
        B_IDLE,
        B_TOTALS,
        B_CHECK,
        B_DIV_MEAN,
        B_MUL_RATIO,
        B_MUL_BYTES,
        B_DIV_QUOT,
        B_MUL_PICO,
        B_MUL_BOOST,
        B_CLAMP,
        B_OUT
    } t_bstate;

endpackage

// ===== rtl/ajst_front.sv =====
module ajst_front
    import ajst_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_data,
    output logic     o_q_valid,
    output t_job     o_q_item,
    input  logic     i_q_pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_job            r_mem [DEPTH];
    logic [AW-1:0]   r_wptr, n_wptr;
    logic [AW-1:0]   r_rptr, n_rptr;
    logic [AW:0]     r_fill, n_fill;
    logic            push;
    logic            pop;
    t_job            job;

    always_comb begin
        job.job_bytes    = i_in_data.job_bytes;
        job.prep_time_us = i_in_data.prep_time_us;
        job.exec_time_us = i_in_data.exec_time_us;
        job.abandoned    = i_in_data.abandoned;
        // A report counts only when it is kept and all three values are nonzero.
        job.taken        = !i_in_data.abandoned && (i_in_data.job_bytes != '0)
                           && (i_in_data.prep_time_us != '0)
                           && (i_in_data.exec_time_us != '0);
    end

    assign o_in_ready = (r_fill != DEPTH[AW:0]);
    assign o_q_valid  = (r_fill != '0);
    assign o_q_item   = r_mem[r_rptr];
    assign push       = i_in_valid && o_in_ready;
    assign pop        = i_q_pop && o_q_valid;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_fill = r_fill;
        if (push) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (pop) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (push && !pop) begin
            n_fill = r_fill + 1'b1;
        end else if (pop && !push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= job;
        end
    end

endmodule

// ===== rtl/ajst_mul.sv =====
module ajst_mul
    import ajst_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [63:0]  i_a,
    input  logic [63:0]  i_b,
    input  logic [6:0]   i_steps,
    output logic         o_busy,
    output logic         o_done,
    output logic [127:0] o_prod
);

    // Shift-and-add, one multiplier bit per cycle, most significant first.
    // The caller left-aligns the multiplier in i_b and gives its width in i_steps.
    logic         r_busy;
    logic         r_done;
    logic [6:0]   r_cnt;
    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic [127:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= {r_acc[126:0], 1'b0} + (r_b[63] ? {64'd0, r_a} : 128'd0);
            r_b   <= {r_b[62:0], 1'b0};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ===== rtl/ajst_div.sv =====
module ajst_div
    import ajst_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_hi,
    input  logic [63:0] i_lo,
    input  logic [63:0] i_d,
    output logic        o_busy,
    output logic        o_done,
    output logic [63:0] o_quot
);

    // Restoring division of a 128-bit dividend, one quotient bit per cycle.
    // A quotient that would not fit in 64 bits, or a zero divisor, saturates.
    logic        r_busy;
    logic        r_done;
    logic [6:0]  r_cnt;
    logic [63:0] r_rem;
    logic [63:0] r_lo;
    logic [63:0] r_d;
    logic [63:0] r_q;
    logic [63:0] shifted;
    logic        take;

    assign shifted = {r_rem[62:0], r_lo[63]};
    assign take    = r_rem[63] || (shifted >= r_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_hi >= i_d) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= 7'd64;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_hi;
            r_lo  <= i_lo;
            r_d   <= i_d;
            r_q   <= (i_hi >= i_d) ? '1 : '0;
        end else if (r_busy) begin
            r_rem <= take ? shifted - r_d : shifted;
            r_lo  <= {r_lo[62:0], 1'b0};
            r_q   <= {r_q[62:0], take};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== rtl/ajst_back.sv =====
module ajst_back
    import ajst_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_load_size,
    input  logic [47:0] i_load_value,
    input  logic        i_q_valid,
    input  t_job        i_q_item,
    output logic        o_q_pop,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data
);

    t_bstate      r_state, n_state;
    t_job         r_item, n_item;
    logic [31:0]  r_count, n_count;
    logic [63:0]  r_prep, n_prep;
    logic [63:0]  r_exec, n_exec;
    logic [63:0]  r_bytes, n_bytes;
    logic [47:0]  r_ideal, n_ideal;
    logic [63:0]  r_iexec, n_iexec;
    logic [63:0]  r_quot, n_quot;
    logic [63:0]  r_target, n_target;
    logic [63:0]  r_upper, n_upper;
    logic         r_out_valid, n_out_valid;
    t_out_item    r_out, n_out;

    logic         mul_start;
    logic [63:0]  mul_a;
    logic [63:0]  mul_b;
    logic [6:0]   mul_steps;
    logic         mul_busy;
    logic         mul_done;
    logic [127:0] mul_prod;
    logic         div_start;
    logic [63:0]  div_hi;
    logic [63:0]  div_lo;
    logic [63:0]  div_d;
    logic         div_busy;
    logic         div_done;
    logic [63:0]  div_quot;

    logic [64:0]  sum_prep;
    logic [64:0]  sum_exec;
    logic [64:0]  sum_bytes;
    logic [63:0]  ratio_exec;
    logic [63:0]  ideal_exec;
    logic [63:0]  cap;
    logic [63:0]  boosted;
    logic [63:0]  lifted;
    logic [63:0]  clamped;

    ajst_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .i_steps (mul_steps),
        .o_busy  (mul_busy),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    ajst_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_hi    (div_hi),
        .i_lo    (div_lo),
        .i_d     (div_d),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign sum_prep  = {1'b0, r_prep}  + {25'd0, r_item.prep_time_us};
    assign sum_exec  = {1'b0, r_exec}  + {25'd0, r_item.exec_time_us};
    assign sum_bytes = {1'b0, r_bytes} + {25'd0, r_item.job_bytes};

    // The ratio is Q8.8, so the product drops eight fraction bits.
    assign ratio_exec = (mul_prod[127:72] != '0) ? '1 : mul_prod[71:8];
    assign ideal_exec = ({24'd0, i_cfg.min_job_time_us} > ratio_exec)
                        ? {24'd0, i_cfg.min_job_time_us} : ratio_exec;
    assign cap        = (mul_prod[127:64] != '0) ? '1 : mul_prod[63:0];
    assign boosted    = {8'd0, mul_prod[63:8]};
    assign lifted     = (r_target < {16'd0, r_ideal}) ? {16'd0, r_ideal} : r_target;
    assign clamped    = (lifted > r_upper) ? r_upper : lifted;

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_count     = r_count;
        n_prep      = r_prep;
        n_exec      = r_exec;
        n_bytes     = r_bytes;
        n_ideal     = r_ideal;
        n_iexec     = r_iexec;
        n_quot      = r_quot;
        n_target    = r_target;
        n_upper     = r_upper;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_q_pop     = 1'b0;
        mul_start   = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        mul_steps   = '0;
        div_start   = 1'b0;
        div_hi      = '0;
        div_lo      = '0;
        div_d       = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_item  = i_q_item;
                    n_state = B_TOTALS;
                end
            end
            B_TOTALS: begin
                if (r_item.taken) begin
                    if (r_count != '1) begin
                        n_count = r_count + 1'b1;
                    end
                    n_prep  = sum_prep[64]  ? '1 : sum_prep[63:0];
                    n_exec  = sum_exec[64]  ? '1 : sum_exec[63:0];
                    n_bytes = sum_bytes[64] ? '1 : sum_bytes[63:0];
                end
                n_state = B_CHECK;
            end
            B_CHECK: begin
                if (r_item.abandoned || r_count == '0) begin
                    n_state = B_OUT;
                end else begin
                    div_start = 1'b1;
                    div_hi    = '0;
                    div_lo    = r_prep;
                    div_d     = {32'd0, r_count};
                    n_state   = B_DIV_MEAN;
                end
            end
            B_DIV_MEAN: begin
                if (div_done) begin
                    mul_start = 1'b1;
                    mul_a     = div_quot;
                    mul_b     = {i_cfg.ratio_q8, 48'd0};
                    mul_steps = 7'd16;
                    n_state   = B_MUL_RATIO;
                end
            end
            B_MUL_RATIO: begin
                if (mul_done) begin
                    n_iexec   = ideal_exec;
                    mul_start = 1'b1;
                    mul_a     = ideal_exec;
                    mul_b     = r_bytes;
                    mul_steps = 7'd64;
                    n_state   = B_MUL_BYTES;
                end
            end
            B_MUL_BYTES: begin
                if (mul_done) begin
                    div_start = 1'b1;
                    div_hi    = mul_prod[127:64];
                    div_lo    = mul_prod[63:0];
                    div_d     = r_exec;
                    n_state   = B_DIV_QUOT;
                end
            end
            B_DIV_QUOT: begin
                if (div_done) begin
                    n_quot    = div_quot;
                    mul_start = 1'b1;
                    mul_a     = r_iexec;
                    mul_b     = {PICO_SCALE, 24'd0};
                    mul_steps = 7'd40;
                    n_state   = B_MUL_PICO;
                end
            end
            B_MUL_PICO: begin
                if (mul_done) begin
                    // The quotient is capped at the ideal exec time in microseconds times PICO_SCALE.
                    n_target  = (r_quot < cap) ? r_quot : cap;
                    mul_start = 1'b1;
                    mul_a     = {16'd0, r_ideal};
                    mul_b     = {i_cfg.boost_q8, 52'd0};
                    mul_steps = 7'd12;
                    n_state   = B_MUL_BOOST;
                end
            end
            B_MUL_BOOST: begin
                if (mul_done) begin
                    n_upper = (boosted > {16'd0, i_cfg.max_size})
                              ? {16'd0, i_cfg.max_size} : boosted;
                    n_state = B_CLAMP;
                end
            end
            B_CLAMP: begin
                n_ideal = clamped[47:0];
                n_state = B_OUT;
            end
            B_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid        = 1'b1;
                    n_out.tuned_size   = r_ideal;
                    n_out.sample_taken = r_item.taken;
                    n_state            = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase

        if (i_load_size) begin
            n_ideal = i_load_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_count     <= '0;
            r_prep      <= '0;
            r_exec      <= '0;
            r_bytes     <= '0;
            r_ideal     <= RST_INITIAL_SIZE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_prep      <= n_prep;
            r_exec      <= n_exec;
            r_bytes     <= n_bytes;
            r_ideal     <= n_ideal;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_iexec  <= n_iexec;
        r_quot   <= n_quot;
        r_target <= n_target;
        r_upper  <= n_upper;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef NO_ASSERTIONS
    a_units_quiet_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_IDLE) |-> (!mul_busy && !div_busy))
        else $error("arithmetic unit busy while the sequencer is idle");

    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_count >= $past(r_count)))
        else $error("sample count decreased");

    a_totals_match_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) == (r_exec == '0))
        else $error("exec total and sample count disagree");

    a_abandoned_not_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_TOTALS && r_item.abandoned) |=> $stable(r_count))
        else $error("abandoned report changed the statistics");
`endif

endmodule

// ===== rtl/adaptive_job_size_tuner_core.sv =====
// Adaptive job size tuner.
// Input channel (i_in_valid / o_in_ready / i_in_data): one beat per completed
// job carrying data size, prepare time, exec time and an abandoned flag.
// Output channel (o_out_valid / i_out_ready / o_out_data): exactly one beat per
// input beat, in order, with the tuned size and whether the report was counted.
// Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data):
// always ready; writing the initial size also reloads the tuned size.
// A small queue holds classified reports so the input side keeps accepting
// while the sequencer works. A report that updates the size runs through the
// serial divider (two 64-step divisions) and the serial multiplier (16, 64, 40
// and 12 steps); an abandoned report, or one seen before any sample is counted,
// skips both units. One report is worked at a time.
// Reset (synchronous, active low) restores register defaults, clears the
// statistics and the queue. If the receiver stalls, the result waits in the
// output register, the sequencer waits after the next result, and the input
// side stops once the queue is full.
module adaptive_job_size_tuner_core
    import ajst_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data
);

    t_cfg        r_cfg;
    logic        cfg_write;
    logic        load_size;
    logic        q_valid;
    logic        q_pop;
    t_job        q_item;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid;
    assign load_size   = cfg_write && (i_cfg_index == CFG_INITIAL_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_size        <= RST_MAX_SIZE;
            r_cfg.min_job_time_us <= RST_MIN_JOB_TIME;
            r_cfg.ratio_q8        <= RST_RATIO_Q8;
            r_cfg.boost_q8        <= RST_BOOST_Q8;
        end else if (cfg_write) begin
            unique case (i_cfg_index)
                // The initial size goes straight into the tuned size in the back part.
                CFG_INITIAL_SIZE: begin
                end
                CFG_MAX_SIZE:     r_cfg.max_size        <= i_cfg_data;
                CFG_MIN_JOB_TIME: r_cfg.min_job_time_us <= i_cfg_data[39:0];
                CFG_RATIO_Q8:     r_cfg.ratio_q8        <= i_cfg_data[15:0];
                CFG_BOOST_Q8:     r_cfg.boost_q8        <= i_cfg_data[11:0];
                default: begin
                end
            endcase
        end
    end

    ajst_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_q_valid  (q_valid),
        .o_q_item   (q_item),
        .i_q_pop    (q_pop)
    );

    ajst_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_load_size  (load_size),
        .i_load_value (i_cfg_data),
        .i_q_valid    (q_valid),
        .i_q_item     (q_item),
        .o_q_pop      (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule
